FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Each macro expects clk and rst_n to be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, disabled while reset is asserted.
`define IPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true.
`define IPF_ASSERT_NEVER(label, cond, msg) \
  `IPF_ASSERT(label, !(cond), msg)

`endif

FILE: rtl/ipf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_pkg
// Shared constants and controller/datapath interface types for the
// integer predicate filter.
// ----------------------------------------------------------------------------
package ipf_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int TDATA_W     = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int CNT_W       = $clog2(VALUE_WIDTH);
  localparam int MODE_W      = 3;

  localparam logic [MODE_W-1:0] MODE_ALL   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_EVEN  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PRIME = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ODD   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TEN   = 3'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture input transfer, restart divisor at 2
    logic div_start;  // clear remainder unit, latch divisor
    logic div_step;   // one restoring remainder step
    logic next_d;     // advance trial divisor and its square
    logic emit;       // load output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              neg;
    logic              mag_le1;
    logic              mag_lsb;
    logic              mag_ten;
    logic              sq_le_n;
    logic              div_last;
    logic              rem_zero;
    logic              out_free;
  } status_t;

endpackage

FILE: rtl/ipf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_datapath
// Mode register, operand capture, divide-by-ten check, trial divisor with
// incremental square, bit-serial remainder unit and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipf_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ipf_pkg::MODE_W-1:0]       cfg_data,
  input  logic [ipf_pkg::VALUE_WIDTH-1:0]  in_value,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic [ipf_pkg::VALUE_WIDTH-1:0]  out_value,
  input  ipf_pkg::cmd_t                    cmd_i,
  output ipf_pkg::status_t                 sts_o
);

  localparam int W   = ipf_pkg::VALUE_WIDTH;
  localparam int NIB = (W + 3) / 4;

  logic [ipf_pkg::MODE_W-1:0] mode_r;
  logic                       out_valid_r;
  logic [W-1:0]               out_data_r;
  logic [W-1:0]               val_r;
  logic [W-1:0]               mag_r;
  logic                       neg_r;
  logic [W-1:0]               d_r;
  logic [2*W-1:0]             sq_r;
  logic [W-1:0]               dv_r;
  logic [W-1:0]               rem_r;
  logic [W-1:0]               sh_r;
  logic [ipf_pkg::CNT_W-1:0]  cnt_r;

  logic [W:0]                 rem_sh;
  logic [W:0]                 rem_sub;
  logic [W-1:0]               rem_nxt;
  logic [W-1:0]               in_mag;
  logic [2*W-1:0]             sq_nxt;
  logic [4*NIB-1:0]           mag_ext;
  logic [7:0]                 nib_sum;
  logic [4:0]                 fold1;
  logic [4:0]                 fold2;

  // Most negative value negates to itself, which read unsigned is 2^(W-1).
  assign in_mag  = in_value[W-1] ? (~in_value + W'(1)) : in_value;

  assign rem_sh  = {rem_r, sh_r[W-1]};
  assign rem_sub = rem_sh - {1'b0, dv_r};
  assign rem_nxt = rem_sub[W] ? rem_sh[W-1:0] : rem_sub[W-1:0];

  // (d+1)^2 = d^2 + 2d + 1
  assign sq_nxt  = sq_r + {{(W-1){1'b0}}, d_r, 1'b0} + (2*W)'(1);

  // 16 = 1 (mod 5): folding nibble sums keeps the residue mod 5
  assign mag_ext = (4*NIB)'(mag_r);

  always_comb begin
    nib_sum = '0;
    for (int i = 0; i < NIB; i++) begin
      nib_sum = nib_sum + 8'(mag_ext[4*i +: 4]);
    end
  end

  assign fold1 = 5'(nib_sum[7:4]) + 5'(nib_sum[3:0]);
  assign fold2 = 5'(fold1[4]) + 5'(fold1[3:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= ipf_pkg::MODE_ALL;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_data;
      end
      if (cmd_i.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      val_r <= in_value;
      neg_r <= in_value[W-1];
      mag_r <= in_mag;
      d_r   <= W'(2);
      sq_r  <= (2*W)'(4);
    end
    if (cmd_i.div_start) begin
      rem_r <= '0;
      cnt_r <= '0;
      sh_r  <= mag_r;
      dv_r  <= d_r;
    end
    if (cmd_i.div_step) begin
      rem_r <= rem_nxt;
      sh_r  <= {sh_r[W-2:0], 1'b0};
      cnt_r <= cnt_r + ipf_pkg::CNT_W'(1);
    end
    if (cmd_i.next_d) begin
      d_r  <= d_r + W'(1);
      sq_r <= sq_nxt;
    end
    if (cmd_i.emit) begin
      out_data_r <= val_r;
    end
  end

  always_comb begin
    sts_o.mode     = mode_r;
    sts_o.neg      = neg_r;
    sts_o.mag_le1  = (mag_r <= W'(1));
    sts_o.mag_lsb  = mag_r[0];
    sts_o.mag_ten  = !mag_r[0] && ((fold2 == 5'd0) || (fold2 == 5'd5) ||
                                   (fold2 == 5'd10) || (fold2 == 5'd15));
    sts_o.sq_le_n  = (sq_r <= {{W{1'b0}}, mag_r});
    sts_o.div_last = (cnt_r == ipf_pkg::CNT_W'(W - 1));
    sts_o.rem_zero = (rem_r == '0);
    sts_o.out_free = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_value  = out_data_r;

  `IPF_ASSERT(a_rem_below_divisor, cmd_i.div_step |=> (rem_r < dv_r), "remainder not reduced")
  `IPF_ASSERT_NEVER(a_emit_overwrite, cmd_i.emit && !sts_o.out_free, "output register overwritten")

endmodule

FILE: rtl/ipf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_ctrl
// Sequencer: picks the predicate, runs the trial division loop and hands
// passing values to the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  ipf_pkg::status_t  sts_i,
  output ipf_pkg::cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_CHECK,
    S_DIV,
    S_DECIDE,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r;
  logic   accept;

  assign accept    = in_tvalid && in_tready_r;
  assign in_tready = in_tready_r;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_EVAL;
        end
      end
      S_EVAL: begin
        case (sts_i.mode)
          ipf_pkg::MODE_ALL:  state_nxt = S_EMIT;
          ipf_pkg::MODE_EVEN: state_nxt = sts_i.mag_lsb ? S_IDLE : S_EMIT;
          ipf_pkg::MODE_ODD:  state_nxt = sts_i.mag_lsb ? S_EMIT : S_IDLE;
          ipf_pkg::MODE_TEN:  state_nxt = sts_i.mag_ten ? S_EMIT : S_IDLE;
          ipf_pkg::MODE_PRIME: begin
            state_nxt = (sts_i.neg || sts_i.mag_le1) ? S_IDLE : S_CHECK;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_CHECK: begin
        // no divisor left with d*d <= n: prime
        if (sts_i.sq_le_n) begin
          cmd_o.div_start = 1'b1;
          state_nxt       = S_DIV;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.rem_zero) begin
          state_nxt = S_IDLE;
        end else begin
          cmd_o.next_d = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= (state_nxt == S_IDLE);
    end
  end

  `IPF_ASSERT(a_ready_only_idle, in_tready_r |-> (state_r == S_IDLE), "ready outside idle")
  `IPF_ASSERT(a_div_runs_out, (state_r == S_DIV && !sts_i.div_last) |=> (state_r == S_DIV),
              "remainder loop cut short")

endmodule

FILE: rtl/integer_predicate_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_predicate_filter_unit
// Passes a signed value through when it meets the predicate set by the
// mode register (all, even, prime, odd, divisible by ten).
// ----------------------------------------------------------------------------
// One value is processed at a time. For all, even, odd and divisible by ten
// the evaluation state decides the predicate; a passing value then waits in
// the emit state until the output register is free, and a value that fails
// returns straight to idle. Divisibility by ten comes from folded nibble sums
// of the magnitude, no divider. Prime testing runs the check, divide and
// decide states for each trial divisor from 2 while d*d <= n, one remainder
// bit per cycle in the divide state. The next value is taken as soon as the
// current one is done, even while the previous result still waits on
// out_tready. Mode writes are accepted at any time but must only be made
// while the unit is idle.
// ----------------------------------------------------------------------------

module integer_predicate_filter_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ipf_pkg::MODE_W-1:0]      cfg_data,   // filter_mode
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ipf_pkg::TDATA_W-1:0]     in_tdata,   // value
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ipf_pkg::TDATA_W-1:0]     out_tdata   // passed_value
);

  ipf_pkg::cmd_t                   cmd;
  ipf_pkg::status_t                sts;
  logic [ipf_pkg::VALUE_WIDTH-1:0] out_value;

  assign cfg_ready = 1'b1;
  assign out_tdata = ipf_pkg::TDATA_W'(out_value);

  ipf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ipf_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .in_value   (in_tdata[ipf_pkg::VALUE_WIDTH-1:0]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_value  (out_value),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

FILE: test/tb_integer_predicate_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_predicate_filter_unit
// Streams signed values through the filter under every mode value, the unused
// ones included. Values are predicted against the selected predicate and the
// outputs are checked in order. Input bursts and output stalls are random.
// ----------------------------------------------------------------------------

module tb_integer_predicate_filter_unit;

  // mode values with no predicate behind them
  localparam logic [ipf_pkg::MODE_W-1:0] MODE_SPARE5 = 3'd5;
  localparam logic [ipf_pkg::MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [ipf_pkg::MODE_W-1:0] MODE_SPARE7 = 3'd7;

  localparam int unsigned IDLE_LIMIT = 300000;

  class filter_scoreboard;
    logic [ipf_pkg::MODE_W-1:0]      mode;
    logic [ipf_pkg::VALUE_WIDTH-1:0] pending[$];
    int                              errors;

    function new();
      mode   = ipf_pkg::MODE_ALL;
      errors = 0;
    endfunction

    function void set_mode(logic [ipf_pkg::MODE_W-1:0] m);
      mode = m;
    endfunction

    // Trial division; tried returns how many divisors were tested.
    function bit trial_divide(bit [ipf_pkg::VALUE_WIDTH-1:0] n, output int unsigned tried);
      bit [ipf_pkg::VALUE_WIDTH-1:0] d;
      tried = 0;
      if (n <= 1) return 1'b0;
      for (d = 2; d <= n / d; d++) begin
        tried++;
        if (n % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function bit meets_predicate(logic [ipf_pkg::VALUE_WIDTH-1:0] raw);
      bit                            neg;
      bit [ipf_pkg::VALUE_WIDTH-1:0] mag;
      int unsigned                   tried;
      neg = raw[ipf_pkg::VALUE_WIDTH-1];
      // most negative value wraps onto itself, which is its unsigned magnitude
      mag = neg ? -raw : raw;
      case (mode)
        ipf_pkg::MODE_ALL:   return 1'b1;
        ipf_pkg::MODE_EVEN:  return !mag[0];
        ipf_pkg::MODE_PRIME: return !neg && trial_divide(mag, tried);
        ipf_pkg::MODE_ODD:   return mag[0];
        ipf_pkg::MODE_TEN:   return (mag % 10) == 0;
        default:             return 1'b0;
      endcase
    endfunction

    function void note_value(logic [ipf_pkg::VALUE_WIDTH-1:0] v);
      if (meets_predicate(v)) pending.push_back(v);
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    task report(string msg);
      $display("%0t ERROR %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [ipf_pkg::VALUE_WIDTH-1:0] got);
      logic [ipf_pkg::VALUE_WIDTH-1:0] want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected output passed_value=%h", got));
      end else begin
        want = pending.pop_front();
        if (got !== want)
          report($sformatf("passed_value got %h want %h", got, want));
      end
    endtask

    task close_out();
      while (pending.size() > 0) begin
        report($sformatf("missing output passed_value=%h", pending.pop_front()));
      end
    endtask
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [ipf_pkg::MODE_W-1:0]   cfg_data;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [ipf_pkg::TDATA_W-1:0]  in_tdata;   // value
  logic                         out_tvalid;
  logic                         out_tready;
  logic [ipf_pkg::TDATA_W-1:0]  out_tdata;  // passed_value

  filter_scoreboard sb;
  int unsigned      burst_left;
  int unsigned      last_drain;
  int unsigned      idle_cycles;
  logic [31:0]      ready_bits;
  logic [4:0]       ready_phase;

  integer_predicate_filter_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Receiver: ready follows a 32-bit pattern, redrawn each round.
  always @(posedge clk) begin
    if (ready_phase == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_bits <= '1;
        1:       ready_bits <= $urandom & $urandom;
        default: ready_bits <= $urandom | $urandom;
      endcase
    end
    ready_phase <= ready_phase + 1'b1;
    out_tready  <= ready_bits[ready_phase];
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[ipf_pkg::VALUE_WIDTH-1:0]);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t timeout: no transfer for %0d cycles", $realtime, idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_value(input logic [ipf_pkg::VALUE_WIDTH-1:0] v);
    int unsigned gap;
    int unsigned tried;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    in_tdata  <= ipf_pkg::TDATA_W'(v);
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_value(v);
    burst_left--;
    // bound on how long the block may still work on this value
    if (sb.mode == ipf_pkg::MODE_PRIME && !v[ipf_pkg::VALUE_WIDTH-1]) begin
      void'(sb.trial_divide(v, tried));
      last_drain = (tried + 4) * (ipf_pkg::VALUE_WIDTH + 4) + 64;
    end else begin
      last_drain = 2 * ipf_pkg::VALUE_WIDTH + 64;
    end
  endtask

  task automatic send_random(input int unsigned count);
    logic [ipf_pkg::VALUE_WIDTH-1:0] v;
    int unsigned                     k;
    repeat (count) begin
      case (sb.mode)
        ipf_pkg::MODE_PRIME: begin
          // keep trial division short: small values, negatives, large evens
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom_range(0, 2000);
            5, 6:          v = $urandom_range(0, 1 << 20);
            7:             v = $urandom | 32'h8000_0000;
            default:       v = $urandom & 32'hFFFF_FFFE;
          endcase
        end
        ipf_pkg::MODE_TEN: begin
          if ($urandom_range(0, 1) == 0) begin
            k = $urandom_range(0, 214748364);
            v = k * 10;
            if ($urandom_range(0, 1) == 0) v = -v;
          end else begin
            v = $urandom;
          end
        end
        default: begin
          if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 40) - 20;
          else v = $urandom;
        end
      endcase
      send_value(v);
    end
  endtask

  // Drop valid, wait out every expected output and the tail of the last value.
  task automatic settle();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (last_drain) @(posedge clk);
  endtask

  task automatic write_mode(input logic [ipf_pkg::MODE_W-1:0] m);
    settle();
    cfg_data  <= m;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_mode(m);
  endtask

  initial begin
    sb          = new();
    burst_left  = 0;
    last_drain  = 0;
    rst_n       <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_data    <= '0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    out_tready  <= 1'b0;
    ready_bits  <= '1;
    ready_phase <= '0;
    idle_cycles <= 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset mode passes everything
    send_value(32'h0000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'hFFFF_FFFF);
    send_value(32'h0000_0001);
    send_random(6);

    write_mode(ipf_pkg::MODE_EVEN);
    send_value(-32'sd4);
    send_value(32'd3);
    send_value(32'h8000_0000);
    send_value(32'd0);
    send_random(10);

    write_mode(ipf_pkg::MODE_PRIME);
    send_value(32'd2);
    send_value(32'd3);
    send_value(32'd1);
    send_value(32'd0);
    send_value(-32'sd7);
    send_value(32'd4);
    send_value(32'd49);
    send_value(32'd65521);
    send_random(14);

    write_mode(ipf_pkg::MODE_ODD);
    send_value(-32'sd3);
    send_value(32'h7FFF_FFFF);
    send_value(-32'sd2);
    send_random(10);

    write_mode(ipf_pkg::MODE_TEN);
    send_value(-32'sd20);
    send_value(32'd10);
    send_value(32'd15);
    send_value(32'h8000_0000);
    send_value(32'd0);
    send_random(10);

    write_mode(MODE_SPARE5);
    send_random(6);
    write_mode(MODE_SPARE7);
    send_random(6);
    write_mode(MODE_SPARE6);
    send_random(4);

    write_mode(ipf_pkg::MODE_ALL);
    send_random(6);
    write_mode(ipf_pkg::MODE_PRIME);
    send_random(6);

    settle();
    sb.close_out();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/ipf_pkg.sv
rtl/ipf_datapath.sv
rtl/ipf_ctrl.sv
rtl/integer_predicate_filter_unit.sv
test/tb_integer_predicate_filter_unit.sv
